// ----- rtl/ajb_pkg.sv -----
// ----------------------------------------------------------------------------
// ajb_pkg
// shared types, sizes and codes for the audio jitter buffer
// ----------------------------------------------------------------------------
package ajb_pkg;

  // ring size and derived widths
  localparam int RING_DEPTH   = 32768;
  localparam int PTR_W        = $clog2(RING_DEPTH);
  localparam int CNT_W        = $clog2(RING_DEPTH + 1);
  localparam int CMP_W        = 18;
  localparam int LEVEL_W      = 15;
  localparam int SAMPLE_W     = 16;
  localparam int WORD_W       = 2 * SAMPLE_W;

  localparam logic [LEVEL_W-1:0] PREBUF_RESET = LEVEL_W'(48000 / 10);
  localparam int UNDERRUN_SHIFT = 2;
  localparam logic [15:0] UNDERRUN_MAX = 16'hFFFF;
  localparam logic [15:0] FILL_MAX     = 16'hFFFF;

  // command codes
  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_PULL = 2'd1;
  localparam logic [1:0] CMD_TRIM = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DROPPED  = 3'd1;
  localparam logic [2:0] ST_PREBUF   = 3'd2;
  localparam logic [2:0] ST_UNDERRUN = 3'd3;
  localparam logic [2:0] ST_TRIMMED  = 3'd4;
  localparam logic [2:0] ST_NOTRIM   = 3'd5;

  typedef struct packed {
    logic [1:0]                 cmd;
    logic signed [SAMPLE_W-1:0] in_right;
    logic signed [SAMPLE_W-1:0] in_left;
  } req_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_right;
    logic signed [SAMPLE_W-1:0] out_left;
    logic                       out_valid;
    logic [2:0]                 status;
    logic [15:0]                fill_level;
  } result_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_t;

endpackage

// ----- rtl/ajb_ram.sv -----
// ----------------------------------------------------------------------------
// ajb_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module ajb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/ajb_ctrl.sv -----
// ----------------------------------------------------------------------------
// ajb_ctrl
// request sequencer: accept, execute, strobe the result
// ----------------------------------------------------------------------------
module ajb_ctrl
  import ajb_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  output logic  busy,
  output logic  done,
  output ctrl_t ctrl
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  assign ctrl.load = start && !busy;
  assign ctrl.exec = (state == S_EXEC);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            state <= S_EXEC;
            busy  <= 1'b1;
          end
        end
        S_EXEC: begin
          state <= S_IDLE;
          busy  <= 1'b0;
          done  <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
          done  <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ----- rtl/ajb_dp.sv -----
// ----------------------------------------------------------------------------
// ajb_dp
// ring pointers, fill and underrun counters, playout latch, result register
// ----------------------------------------------------------------------------
module ajb_dp
  import ajb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  ctrl_t              ctrl,
  input  req_t               req,
  input  logic               cfg_we,
  input  logic [LEVEL_W-1:0] cfg_data,
  output result_t            result
);

  logic [PTR_W-1:0]   rd_ptr, rd_ptr_next;
  logic [PTR_W-1:0]   wr_ptr, wr_ptr_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [15:0]        underruns, underruns_next;
  logic               started, started_next;
  logic [LEVEL_W-1:0] level;
  req_t               req_q;
  result_t            result_next;

  logic [WORD_W-1:0]  ram_rdata;
  logic               ram_we;

  logic [CMP_W-1:0]   count_w, level_w, trim_base;
  logic [PTR_W-1:0]   wr_ptr_inc, rd_ptr_inc, trim_rp;
  logic               full, trim_ok, pull_started;

  assign count_w = CMP_W'(count);
  assign level_w = CMP_W'(level);
  assign full    = count_w >= CMP_W'(RING_DEPTH);

  assign wr_ptr_inc = (wr_ptr == PTR_W'(RING_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
  assign rd_ptr_inc = (rd_ptr == PTR_W'(RING_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;

  assign trim_ok = (count_w > (level_w << 1)) &&
                   (CMP_W'(underruns) > CMP_W'(level >> UNDERRUN_SHIFT));

  // keep the newest level entries: read pointer sits level behind write
  assign trim_base = (CMP_W'(wr_ptr) >= level_w) ? CMP_W'(wr_ptr)
                                                 : CMP_W'(wr_ptr) + CMP_W'(RING_DEPTH);
  assign trim_rp   = PTR_W'(trim_base - level_w);

  assign pull_started = started || (count_w >= level_w);

  assign ram_we = ctrl.exec && (req_q.cmd == CMD_PUSH) && !full;

  ajb_ram #(
    .WIDTH (WORD_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr),
    .wdata ({req_q.in_left, req_q.in_right}),
    .raddr (rd_ptr),
    .rdata (ram_rdata)
  );

  always_comb begin
    rd_ptr_next    = rd_ptr;
    wr_ptr_next    = wr_ptr;
    count_next     = count;
    underruns_next = underruns;
    started_next   = started;
    result_next    = '0;
    result_next.status = ST_OK;

    case (req_q.cmd)
      CMD_PUSH: begin
        if (full) begin
          result_next.status = ST_DROPPED;
        end else begin
          wr_ptr_next = wr_ptr_inc;
          count_next  = count + 1'b1;
        end
        if (CMP_W'(count_next) >= level_w) begin
          started_next = 1'b1;
        end
      end
      CMD_PULL: begin
        started_next = pull_started;
        if (!pull_started) begin
          result_next.status = ST_PREBUF;
        end else if (count == '0) begin
          result_next.status = ST_UNDERRUN;
          if (underruns != UNDERRUN_MAX) begin
            underruns_next = underruns + 1'b1;
          end
        end else begin
          result_next.out_right = ram_rdata[SAMPLE_W-1:0];
          result_next.out_left  = ram_rdata[WORD_W-1:SAMPLE_W];
          result_next.out_valid = 1'b1;
          rd_ptr_next = rd_ptr_inc;
          count_next  = count - 1'b1;
        end
      end
      CMD_TRIM: begin
        if (trim_ok) begin
          rd_ptr_next    = trim_rp;
          count_next     = CNT_W'(level);
          underruns_next = '0;
          result_next.status = ST_TRIMMED;
        end else begin
          result_next.status = ST_NOTRIM;
        end
      end
      default: begin
        result_next.status = ST_OK;
      end
    endcase

    result_next.fill_level = (CMP_W'(count_next) > CMP_W'(FILL_MAX)) ? FILL_MAX
                                                                     : 16'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr    <= '0;
      wr_ptr    <= '0;
      count     <= '0;
      underruns <= '0;
      started   <= 1'b0;
      level     <= PREBUF_RESET;
    end else begin
      if (cfg_we) begin
        level <= cfg_data;
      end
      if (ctrl.exec) begin
        rd_ptr    <= rd_ptr_next;
        wr_ptr    <= wr_ptr_next;
        count     <= count_next;
        underruns <= underruns_next;
        started   <= started_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      req_q <= req;
    end
    if (ctrl.exec) begin
      result <= result_next;
    end
  end

endmodule

// ----- rtl/audio_jitter_buffer_unit.sv -----
// ----------------------------------------------------------------------------
// audio_jitter_buffer_unit
// stereo 16-bit jitter buffer: push, pull and trim on a sample ring
// ----------------------------------------------------------------------------
//
//   channel   handshake             payload
//   -------   --------------------  ---------------------------------------
//   request   start / busy          req    (cmd, in_right, in_left)
//   result    done (one-cycle)      result (out_right, out_left, out_valid,
//                                           status, fill_level)
//   config    cfg_we                cfg_data (prebuffer level)
//
// a request is taken on an edge with start high and busy low; busy is then
// high for one execute cycle in which the ring is written, its prefetched
// head entry is used or the read pointer is moved back by a trim
// done pulses for one cycle right after the execute cycle; a new request may
// be taken in that same cycle, the receiver cannot hold results off
// the ring ram read port always fetches the entry at the read pointer, so a
// pull finds its pair ready in the execute cycle
// rst is synchronous; it clears pointers, counters and the playout latch and
// loads the default prebuffer level; ring contents are left as they are
//
module audio_jitter_buffer_unit
  import ajb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  req_t               req,
  output logic               done,
  output result_t            result,
  input  logic               cfg_we,
  input  logic [LEVEL_W-1:0] cfg_data
);

  // load / execute commands from the sequencer
  ctrl_t ctrl;

  ajb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctrl  (ctrl)
  );

  // ring, counters, playout latch and result register
  ajb_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .req      (req),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .result   (result)
  );

endmodule
